// ----- hw/rtl/yaz0_pkg.sv -----
`timescale 1ns / 1ps
package yaz0_pkg;

    // History window
    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);

    // Result grouping
    localparam int LANES   = 8;
    localparam int LANE_W  = $clog2(LANES);
    localparam int OUT_W   = 8 * LANES;
    localparam int COUNT_W = 4;

    // Copy length: nibble + 2, or extra byte + 18, at most 273
    localparam int LEN_W        = 9;
    localparam int SHORT_BIAS   = 2;
    localparam int LONG_BIAS    = 18;

    // Command queue between parser and copy engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int SIZE_W = 32;

    typedef struct packed {
        logic              is_lit;
        logic [7:0]        lit;
        logic [LEN_W-1:0]  len;
        logic [WIN_AW-1:0] dist_m1;
        logic              done;
    } t_cmd;

endpackage

// ----- hw/rtl/yaz0_in_if.sv -----
`timescale 1ns / 1ps
interface yaz0_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] compressed_byte;
    logic       start_of_stream;

    modport source (output valid, output compressed_byte, output start_of_stream, input ready);
    modport sink (input valid, input compressed_byte, input start_of_stream, output ready);
endinterface

// ----- hw/rtl/yaz0_out_if.sv -----
`timescale 1ns / 1ps
interface yaz0_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  out_count;
    logic        last_in_run;
    logic        stream_done;

    modport source (output valid, output out_bytes, output out_count, output last_in_run,
                    output stream_done, input ready);
    modport sink (input valid, input out_bytes, input out_count, input last_in_run,
                  input stream_done, output ready);
endinterface

// ----- hw/rtl/yaz0_front.sv -----
`timescale 1ns / 1ps
module yaz0_front import yaz0_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_sos,
    input  logic [SIZE_W-1:0] i_size,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output t_cmd              o_cmd
);

    typedef enum logic [3:0] {
        ST_FLAG   = 4'b0001,
        ST_TOKEN  = 4'b0010,
        ST_SECOND = 4'b0100,
        ST_EXTRA  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [7:0]        r_flags, n_flags;
    logic [3:0]        r_left, n_left;
    logic [3:0]        r_nib, n_nib;
    logic [WIN_AW-1:0] r_dist, n_dist;
    logic [SIZE_W-1:0] r_prod, n_prod;

    logic              accept;
    t_state            st_cur;
    logic [SIZE_W-1:0] prod_cur;
    logic [SIZE_W-1:0] rem;
    logic [LEN_W-1:0]  full_len;
    logic [LEN_W-1:0]  take;
    logic [3:0]        left_dec;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Parse one byte and emit literal or copy commands
    always_comb begin
        st_cur   = i_sos ? ST_FLAG : r_state;
        prod_cur = i_sos ? '0 : r_prod;
        rem      = i_size - prod_cur;
        left_dec = (r_left != 4'd0) ? r_left - 4'd1 : 4'd0;
        full_len = (st_cur == ST_EXTRA)
                 ? LEN_W'({1'b0, i_byte}) + LEN_W'(LONG_BIAS)
                 : LEN_W'(r_nib) + LEN_W'(SHORT_BIAS);
        take     = (rem < SIZE_W'(full_len)) ? rem[LEN_W-1:0] : full_len;

        n_state = r_state;
        n_flags = r_flags;
        n_left  = r_left;
        n_nib   = r_nib;
        n_dist  = r_dist;
        n_prod  = r_prod;
        o_push  = 1'b0;
        o_cmd   = '0;

        if (accept) begin
            if (i_sos) begin
                n_state = ST_FLAG;
                n_flags = '0;
                n_left  = '0;
                n_nib   = '0;
                n_dist  = '0;
                n_prod  = '0;
            end
            if (prod_cur < i_size) begin
                case (st_cur)
                    ST_TOKEN: begin
                        if (r_flags[7]) begin
                            o_push       = 1'b1;
                            o_cmd.is_lit = 1'b1;
                            o_cmd.lit    = i_byte;
                            o_cmd.len    = LEN_W'(1);
                            o_cmd.done   = (rem == SIZE_W'(1));
                            n_prod       = prod_cur + SIZE_W'(1);
                            n_flags      = {r_flags[6:0], 1'b0};
                            n_left       = left_dec;
                            n_state      = (left_dec == 4'd0) ? ST_FLAG : ST_TOKEN;
                        end else begin
                            n_nib   = i_byte[7:4];
                            n_dist  = {i_byte[3:0], 8'd0};
                            n_state = ST_SECOND;
                        end
                    end
                    ST_SECOND: begin
                        n_dist = {r_dist[11:8], i_byte};
                        if (r_nib == 4'd0) begin
                            n_state = ST_EXTRA;
                        end else begin
                            o_push        = 1'b1;
                            o_cmd.len     = take;
                            o_cmd.dist_m1 = {r_dist[11:8], i_byte};
                            o_cmd.done    = (rem <= SIZE_W'(full_len));
                            n_prod        = prod_cur + SIZE_W'(take);
                            n_flags       = {r_flags[6:0], 1'b0};
                            n_left        = left_dec;
                            n_state       = (left_dec == 4'd0) ? ST_FLAG : ST_TOKEN;
                        end
                    end
                    ST_EXTRA: begin
                        o_push        = 1'b1;
                        o_cmd.len     = take;
                        o_cmd.dist_m1 = r_dist;
                        o_cmd.done    = (rem <= SIZE_W'(full_len));
                        n_prod        = prod_cur + SIZE_W'(take);
                        n_flags       = {r_flags[6:0], 1'b0};
                        n_left        = left_dec;
                        n_state       = (left_dec == 4'd0) ? ST_FLAG : ST_TOKEN;
                    end
                    default: begin
                        n_flags = i_byte;
                        n_left  = 4'd8;
                        n_state = ST_TOKEN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FLAG;
            r_flags <= '0;
            r_left  <= '0;
            r_nib   <= '0;
            r_dist  <= '0;
            r_prod  <= '0;
        end else begin
            r_state <= n_state;
            r_flags <= n_flags;
            r_left  <= n_left;
            r_nib   <= n_nib;
            r_dist  <= n_dist;
            r_prod  <= n_prod;
        end
    end

endmodule

// ----- hw/rtl/yaz0_queue.sv -----
`timescale 1ns / 1ps
module yaz0_queue import yaz0_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_slot[r_rd];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QUEUE_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QUEUE_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hw/rtl/yaz0_back.sv -----
`timescale 1ns / 1ps
module yaz0_back import yaz0_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_cmd i_cmd,
    output logic o_pop,
    yaz0_out_if.source out_ch
);

    logic [7:0]        r_hist [WIN_DEPTH];
    logic [7:0]        r_mem_q;

    // Issue stage
    logic              r_active;
    logic              r_lit;
    logic [7:0]        r_lit_byte;
    logic [LEN_W-1:0]  r_len;
    logic [WIN_AW-1:0] r_src;
    logic              r_fwd;
    logic              r_done;
    logic [WIN_AW-1:0] r_wp;
    logic              r_filled;

    // Write and pack stage
    logic              r_s2_valid;
    logic              r_s2_lit;
    logic [7:0]        r_s2_byte;
    logic              r_s2_fwd;
    logic              r_s2_ok;
    logic [WIN_AW-1:0] r_s2_waddr;
    logic              r_s2_last;
    logic              r_s2_done;
    logic [7:0]        r_last;
    logic [OUT_W-1:0]  r_acc;
    logic [LANE_W-1:0] r_lane;

    // Output register
    logic              r_ovalid;
    logic [OUT_W-1:0]  r_obytes;
    logic [COUNT_W-1:0] r_ocount;
    logic              r_olast;
    logic              r_odone;

    logic              s2_close;
    logic              issue;
    logic [7:0]        s2_val;
    logic [OUT_W-1:0]  acc_next;

    assign s2_close = r_s2_valid && (r_s2_last || (r_lane == LANE_W'(LANES-1)));
    assign issue    = r_active && (!r_ovalid || out_ch.ready) && !s2_close;
    assign o_pop    = !r_active && !i_empty;

    // Resolve the byte: literal, previous byte, history or never written
    always_comb begin
        if (r_s2_lit) begin
            s2_val = r_s2_byte;
        end else if (r_s2_fwd) begin
            s2_val = r_last;
        end else if (r_s2_ok) begin
            s2_val = r_mem_q;
        end else begin
            s2_val = '0;
        end
        acc_next = r_acc | (OUT_W'(s2_val) << (8 * r_lane));
    end

    // History memory
    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_hist[r_s2_waddr] <= s2_val;
        end
        r_mem_q <= r_hist[r_src];
    end

    // Load commands and issue one byte per cycle while the output can take a beat and no group closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_wp       <= '0;
            r_filled   <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= issue;
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (issue && (r_len == LEN_W'(1))) begin
                r_active <= 1'b0;
            end
            if (issue) begin
                r_wp <= r_wp + WIN_AW'(1);
                if (r_wp == WIN_AW'(WIN_DEPTH-1)) begin
                    r_filled <= 1'b1;
                end
            end
        end
    end

    // Command payload and stage-two payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_lit      <= i_cmd.is_lit;
            r_lit_byte <= i_cmd.lit;
            r_len      <= i_cmd.len;
            r_src      <= r_wp - i_cmd.dist_m1 - WIN_AW'(1);
            r_fwd      <= (i_cmd.dist_m1 == '0);
            r_done     <= i_cmd.done;
        end else if (issue) begin
            r_len <= r_len - LEN_W'(1);
            r_src <= r_src + WIN_AW'(1);
        end
        if (issue) begin
            r_s2_lit   <= r_lit;
            r_s2_byte  <= r_lit_byte;
            r_s2_fwd   <= r_fwd;
            r_s2_ok    <= r_filled || (r_src < r_wp);
            r_s2_waddr <= r_wp;
            r_s2_last  <= (r_len == LEN_W'(1));
            r_s2_done  <= r_done;
        end
    end

    // Pack bytes into groups and hold the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_acc    <= '0;
            r_lane   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && out_ch.ready && !s2_close) begin
                r_ovalid <= 1'b0;
            end
            if (r_s2_valid) begin
                r_last <= s2_val;
                if (s2_close) begin
                    r_ovalid <= 1'b1;
                    r_obytes <= acc_next;
                    r_ocount <= COUNT_W'(r_lane) + COUNT_W'(1);
                    r_olast  <= r_s2_last;
                    r_odone  <= r_s2_last && r_s2_done;
                    r_acc    <= '0;
                    r_lane   <= '0;
                end else begin
                    r_acc  <= acc_next;
                    r_lane <= r_lane + LANE_W'(1);
                end
            end
        end
    end

    assign out_ch.valid       = r_ovalid;
    assign out_ch.out_bytes   = r_obytes;
    assign out_ch.out_count   = r_ocount;
    assign out_ch.last_in_run = r_olast;
    assign out_ch.stream_done = r_odone;

endmodule

// ----- hw/rtl/yaz0_decompressor.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Payload                                          Beat
// in_ch     in   compressed_byte[7:0], start_of_stream            valid & ready
// out_ch    out  out_bytes[63:0], out_count[3:0], last_in_run,    valid & ready
//                stream_done
// cfg       in   i_cfg_data[31:0] (decoded_size)                   i_cfg_we
//
// The parser takes one compressed byte per cycle while its 4-entry command queue
// has room. The copy engine writes one decoded byte per cycle, save while a group
// closes, into the 4096-byte history; it loads the next command (up to 273 bytes)
// once the last is issued. Groups hold up to eight bytes. History reads as zero
// until written, tracked by the write pointer and a wrap flag. Reset is synchronous,
// active low. A stalled output holds the engine; a full queue holds the input.
module yaz0_decompressor import yaz0_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    yaz0_in_if.sink           in_ch,
    yaz0_out_if.source        out_ch,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    logic [SIZE_W-1:0] r_size;
    logic              q_full;
    logic              q_empty;
    logic              push;
    logic              pop;
    t_cmd              push_cmd;
    t_cmd              head_cmd;

    // Hold the decoded size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
        end
    end

    yaz0_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_ch.valid),
        .i_byte   (in_ch.compressed_byte),
        .i_sos    (in_ch.start_of_stream),
        .i_size   (r_size),
        .i_q_full (q_full),
        .o_ready  (in_ch.ready),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    yaz0_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    yaz0_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .out_ch  (out_ch)
    );

endmodule

// ----- dv/tb_yaz0_if.sv -----
`timescale 1ns / 1ps
// Testbench-side copies of the channel interfaces are provided by the RTL;
// this file holds a small helper interface bundle for the stall controls.
interface tb_yaz0_knobs_if;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
endinterface

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import yaz0_pkg::*;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        last;
        logic        done;
    } t_group;

    typedef struct packed {
        logic [7:0] data;
        logic       sos;
    } t_stim;

    localparam logic [2:0] PH_FLAG   = 3'd0;
    localparam logic [2:0] PH_TOKEN  = 3'd1;
    localparam logic [2:0] PH_SECOND = 3'd2;
    localparam logic [2:0] PH_EXTRA  = 3'd3;
    localparam int         WATCHDOG  = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;

    yaz0_in_if  in_ch ();
    yaz0_out_if out_ch ();
    tb_yaz0_knobs_if knobs ();

    yaz0_decompressor DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state
    logic [7:0]  win [WIN_DEPTH];
    logic [11:0] wr_ptr;
    logic [7:0]  flag_bits;
    logic [3:0]  flag_cnt;
    logic [2:0]  phase;
    logic [3:0]  nib;
    logic [11:0] dist_m1;
    logic [31:0] made_cnt;
    logic [31:0] size_reg;

    t_group groups_due[$];
    int     n_fail;
    int     n_groups;
    int     n_bytes_in;
    int     idle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Advance to next token or back to flag byte
    function automatic void step_flag();
        flag_bits = flag_bits << 1;
        if (flag_cnt != 0) flag_cnt--;
        phase = (flag_cnt == 0) ? PH_FLAG : PH_TOKEN;
    endfunction

    // Produce decoded bytes and queue grouped results
    function automatic void produce(bit is_lit, logic [7:0] lit, int len);
        int         lane;
        logic [63:0] acc;
        logic [7:0] b;
        int         first_q;
        lane = 0;
        acc = '0;
        first_q = groups_due.size();
        for (int i = 0; i < len && made_cnt < size_reg; i++) begin
            b = is_lit ? lit : win[wr_ptr - dist_m1 - 12'd1];
            win[wr_ptr] = b;
            wr_ptr++;
            made_cnt++;
            acc |= 64'(b) << (8 * lane);
            lane++;
            if (lane == LANES) begin
                groups_due.push_back('{acc, 4'(lane), 1'b0, made_cnt >= size_reg});
                lane = 0;
                acc = '0;
            end
        end
        if (lane > 0)
            groups_due.push_back('{acc, 4'(lane), 1'b0, made_cnt >= size_reg});
        if (groups_due.size() > first_q)
            groups_due[groups_due.size() - 1].last = 1'b1;
    endfunction

    // Decode one accepted compressed byte
    function automatic void decode_byte(logic [7:0] d, logic sos);
        if (sos) begin
            phase = PH_FLAG; flag_bits = 0; flag_cnt = 0;
            nib = 0; dist_m1 = 0; made_cnt = 0;
        end
        if (made_cnt >= size_reg) return;
        case (phase)
            PH_TOKEN: begin
                if (flag_bits[7]) begin
                    produce(1'b1, d, 1);
                    step_flag();
                end else begin
                    nib = d[7:4];
                    dist_m1 = {d[3:0], 8'h00};
                    phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                dist_m1 = {dist_m1[11:8], d};
                if (nib == 0) phase = PH_EXTRA;
                else begin
                    produce(1'b0, 8'h00, nib + SHORT_BIAS);
                    step_flag();
                end
            end
            PH_EXTRA: begin
                produce(1'b0, 8'h00, d + LONG_BIAS);
                step_flag();
            end
            default: begin
                flag_bits = d;
                flag_cnt = 8;
                phase = PH_TOKEN;
            end
        endcase
    endfunction

    // Check result beats against the oldest expectation
    always @(posedge i_clk) begin
        t_group got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.out_bytes, out_ch.out_count, out_ch.last_in_run, out_ch.stream_done};
            n_groups++;
            if (groups_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                n_fail++;
            end else begin
                want = groups_due.pop_front();
                if (got.bytes !== want.bytes) begin
                    $display("%0t: out_bytes expected %h actual %h", $time, want.bytes, got.bytes);
                    n_fail++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: out_count expected %0d actual %0d", $time, want.count, got.count);
                    n_fail++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last_in_run expected %b actual %b", $time, want.last, got.last);
                    n_fail++;
                end
                if (got.done !== want.done) begin
                    $display("%0t: stream_done expected %b actual %b", $time, want.done, got.done);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WATCHDOG) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG);
            $display("** yaz0_decompressor: FAILED **");
            $finish;
        end
    end

    // Receiver stall
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= knobs.snk_idle_pct);
    end

    // Drive one beat; valid stays high into the next byte unless the sender idles
    task automatic send_byte(logic [7:0] d, logic sos);
        while ($urandom_range(99) < knobs.src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.compressed_byte <= d;
        in_ch.start_of_stream <= sos;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        decode_byte(d, sos);
        n_bytes_in++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (groups_due.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic set_size(logic [31:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        size_reg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Send one well-formed group of eight tokens with random content
    task automatic send_group(bit first);
        logic [7:0] fl;
        logic [7:0] b;
        fl = 8'($urandom);
        send_byte(fl, first);
        for (int t = 7; t >= 0; t--) begin
            if (fl[t]) send_byte(8'($urandom), 1'b0);
            else begin
                b = 8'($urandom);
                if ($urandom_range(3) == 0) b[7:4] = 4'h0;
                send_byte(b, 1'b0);
                send_byte(8'($urandom), 1'b0);
                if (b[7:4] == 0)
                    send_byte(($urandom_range(7) == 0) ? 8'hff : 8'($urandom_range(20)), 1'b0);
            end
        end
    endtask

    // Directed rows: byte, start flag
    t_stim dir_rows [22] = '{
        '{8'hff, 1'b1}, '{8'h00, 1'b0}, '{8'hff, 1'b0}, '{8'h5a, 1'b0}, '{8'ha5, 1'b0},
        '{8'h01, 1'b0}, '{8'h80, 1'b0}, '{8'h7f, 1'b0}, '{8'h10, 1'b0},
        '{8'h00, 1'b0}, '{8'hf0, 1'b0}, '{8'h01, 1'b0}, '{8'h00, 1'b0},
        '{8'h0f, 1'b0}, '{8'hff, 1'b0}, '{8'hff, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0},
        '{8'h12, 1'b0}, '{8'h34, 1'b0}, '{8'h56, 1'b0}, '{8'h78, 1'b0}
    };

    initial begin
        t_group first_row;
        n_fail = 0; n_groups = 0; n_bytes_in = 0; idle_cnt = 0;
        knobs.src_idle_pct = 17;
        knobs.snk_idle_pct = 51;
        in_ch.valid = 1'b0;
        in_ch.compressed_byte = '0;
        in_ch.start_of_stream = 1'b0;
        out_ch.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        foreach (win[i]) win[i] = '0;
        wr_ptr = 0; flag_bits = 0; flag_cnt = 0; phase = PH_FLAG;
        nib = 0; dist_m1 = 0; made_cnt = 0; size_reg = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Size zero after reset: input ignored
        send_byte(8'hff, 1'b1);
        send_byte(8'h41, 1'b0);
        set_size(32'd200);
        // Directed table: the first literal is typed, the rest is predicted
        for (int r = 0; r < $size(dir_rows); r++) begin
            send_byte(dir_rows[r].data, dir_rows[r].sos);
            if (r == 1) begin
                first_row = groups_due[0];
                if (first_row !== t_group'{64'h0, 4'd1, 1'b1, 1'b0}) begin
                    $display("%0t: first literal expected %h actual %h", $time,
                             t_group'{64'h0, 4'd1, 1'b1, 1'b0}, first_row);
                    n_fail++;
                end
            end
        end
        // Copy past the end, then further bytes ignored
        set_size(32'd5);
        send_byte(8'h00, 1'b1);
        send_byte(8'hf0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h61, 1'b0);
        set_size(32'hffff_ffff);

        for (int ph = 0; ph < 3; ph++) begin
            knobs.src_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 51 : 0;
            knobs.snk_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 17 : 0;
            for (int g = 0; g < 1; g++) begin
                if ($urandom_range(4) == 0) send_byte(8'($urandom), 1'($urandom_range(1)));
                send_group(g == 0);
            end
            // Hold until everything is out, then change size mid-run
            drain();
            set_size(ph == 2 ? 32'd1 : 32'($urandom_range(60, 400)));
            send_group(1'b1);
        end
        drain();

        $display("Run covered %0d input bytes and %0d result groups, sizes from 0 to max,",
                 n_bytes_in, n_groups);
        $display("literals, short and long copies, truncation and stream restarts.");
        if (n_fail == 0 && groups_due.size() == 0) begin
            $display("** yaz0_decompressor: PASSED **");
        end else begin
            $display("** yaz0_decompressor: FAILED **");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/yaz0_pkg.sv
hw/rtl/yaz0_in_if.sv
hw/rtl/yaz0_out_if.sv
hw/rtl/yaz0_front.sv
hw/rtl/yaz0_queue.sv
hw/rtl/yaz0_back.sv
hw/rtl/yaz0_decompressor.sv
dv/tb_yaz0_if.sv
dv/tb_top.sv
